// ===== src/ctt_pkg.sv =====
package ctt_pkg;

  localparam int CODE_BITS_DEF = 8;
  localparam int CMD_W = 3;
  localparam int CODE_W = 8;
  localparam int ST_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TRANS   = 3'd0,
    CMD_REV     = 3'd1,
    CMD_SET     = 3'd2,
    CMD_UNSET   = 3'd3,
    CMD_RESTORE = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_ORDER    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WR_IDENT,
    WR_MAP,
    WR_ZERO
  } wr_kind_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_DATA,
    RES_ADDR
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     in_ready;
    logic     idx_clr;
    logic     idx_lo;
    logic     idx_inc;
    logic     val_ld;
    logic     rd_en;
    logic     rd_lo;
    logic     wr_en;
    wr_kind_t wr_kind;
    logic     res_set;
    status_t  res_st;
    res_sel_t res_sel;
    logic     ld_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    cmd_t cmd;
    logic lo_big;
    logic order_bad;
    logic hi_big;
    logic set_ovf;
    logic idx_at_hi;
    logic idx_last;
    logic idx_done;
    logic rd_vbit;
    logic hit;
    logic last_rd;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/ctt_if.sv =====
interface ctt_in_if;
  logic                         valid;
  logic                         ready;
  logic [ctt_pkg::CMD_W-1:0]    cmd;
  logic [ctt_pkg::CODE_W-1:0]   code_first;
  logic [ctt_pkg::CODE_W-1:0]   code_last;
  logic [ctt_pkg::CODE_W-1:0]   target_code;

  modport source(output valid, cmd, code_first, code_last, target_code, input ready);
  modport sink(input valid, cmd, code_first, code_last, target_code, output ready);
endinterface

interface ctt_out_if;
  logic                         valid;
  logic                         ready;
  logic [ctt_pkg::ST_W-1:0]     status;
  logic [ctt_pkg::CODE_W-1:0]   result_code;

  modport source(output valid, status, result_code, input ready);
  modport sink(input valid, status, result_code, output ready);
endinterface

// ===== src/ctt_ctrl.sv =====
module ctt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  ctt_pkg::dp_stat_t   stat,
  output ctt_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FWD,
    S_SRCH,
    S_WALK,
    S_REST,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.wr_kind = ctt_pkg::WR_IDENT;
    cmd.res_st  = ctt_pkg::ST_OK;
    cmd.res_sel = ctt_pkg::RES_ZERO;
    case (state_r)
      S_INIT: begin
        // clearing pass: load the identity map
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.cmd)
          ctt_pkg::CMD_TRANS: begin
            if (stat.lo_big) begin
              cmd.res_set = 1'b1;
              cmd.res_st  = ctt_pkg::ST_MISSING;
              state_nxt   = S_FINISH;
            end else begin
              cmd.rd_en = 1'b1;
              cmd.rd_lo = 1'b1;
              state_nxt = S_FWD;
            end
          end
          ctt_pkg::CMD_REV: begin
            if (stat.lo_big) begin
              cmd.res_set = 1'b1;
              cmd.res_st  = ctt_pkg::ST_MISSING;
              state_nxt   = S_FINISH;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_SRCH;
            end
          end
          ctt_pkg::CMD_SET, ctt_pkg::CMD_UNSET: begin
            if (stat.order_bad) begin
              cmd.res_set = 1'b1;
              cmd.res_st  = ctt_pkg::ST_ORDER;
              state_nxt   = S_FINISH;
            end else if (stat.hi_big ||
                         (stat.cmd == ctt_pkg::CMD_SET && stat.set_ovf)) begin
              cmd.res_set = 1'b1;
              cmd.res_st  = ctt_pkg::ST_OVERFLOW;
              state_nxt   = S_FINISH;
            end else begin
              cmd.idx_lo = 1'b1;
              cmd.val_ld = 1'b1;
              state_nxt  = S_WALK;
            end
          end
          ctt_pkg::CMD_RESTORE: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_REST;
          end
          default: begin
            cmd.res_set = 1'b1;
            state_nxt   = S_FINISH;
          end
        endcase
      end
      S_FWD: begin
        cmd.res_set = 1'b1;
        if (stat.rd_vbit) begin
          cmd.res_sel = ctt_pkg::RES_DATA;
        end else begin
          cmd.res_st = ctt_pkg::ST_MISSING;
        end
        state_nxt = S_FINISH;
      end
      S_SRCH: begin
        // one read issued per cycle, compare the word from the previous read
        cmd.rd_en   = !stat.idx_done;
        cmd.idx_inc = !stat.idx_done;
        if (stat.hit) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = ctt_pkg::RES_ADDR;
          state_nxt   = S_FINISH;
        end else if (stat.last_rd) begin
          cmd.res_set = 1'b1;
          cmd.res_st  = ctt_pkg::ST_MISSING;
          state_nxt   = S_FINISH;
        end
      end
      S_WALK: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = (stat.cmd == ctt_pkg::CMD_SET) ? ctt_pkg::WR_MAP : ctt_pkg::WR_ZERO;
        cmd.idx_inc = 1'b1;
        if (stat.idx_at_hi) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FINISH;
        end
      end
      S_REST: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_last) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/ctt_dpath.sv =====
module ctt_dpath #(
  parameter int CODE_BITS = ctt_pkg::CODE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  ctt_in_if.sink              in_ch,
  ctt_out_if.source           out_ch,
  input  ctt_pkg::ctrl_cmd_t  cmd,
  output ctt_pkg::dp_stat_t   stat
);

  localparam int TABLE = 1 << CODE_BITS;
  localparam int CW = (CODE_BITS > ctt_pkg::CODE_W) ? CODE_BITS + 1 : ctt_pkg::CODE_W + 1;
  localparam logic [CW-1:0] MAX_X = CW'(TABLE - 1);
  localparam logic [CODE_BITS-1:0] MAX_A = {CODE_BITS{1'b1}};

  // entry: {valid, mapped code}
  logic [CODE_BITS:0] mem [TABLE];

  logic [ctt_pkg::CMD_W-1:0]  cmd_r;
  logic [ctt_pkg::CODE_W-1:0] lo_r, hi_r, tgt_r;
  logic [CODE_BITS:0]         idx_r;
  logic [CODE_BITS-1:0]       val_r;
  logic [CODE_BITS:0]         rd_r;
  logic [CODE_BITS-1:0]       addr_r;
  logic                       pend_r;
  logic [ctt_pkg::ST_W-1:0]   pend_st_r;
  logic [ctt_pkg::CODE_W-1:0] pend_code_r;
  logic                       out_valid_r;
  logic [ctt_pkg::ST_W-1:0]   out_st_r;
  logic [ctt_pkg::CODE_W-1:0] out_code_r;

  logic [CW-1:0]        lo_x, hi_x, tgt_x, span_end, res_x;
  logic [CODE_BITS-1:0] raddr, waddr;
  logic [CODE_BITS:0]   wdata;
  logic                 accept;

  assign accept   = in_ch.valid && cmd.in_ready;
  assign lo_x     = CW'(lo_r);
  assign hi_x     = CW'(hi_r);
  assign tgt_x    = CW'(tgt_r);
  assign span_end = tgt_x + (hi_x - lo_x);
  assign waddr    = idx_r[CODE_BITS-1:0];
  assign raddr    = cmd.rd_lo ? lo_x[CODE_BITS-1:0] : idx_r[CODE_BITS-1:0];

  always_comb begin
    case (cmd.wr_kind)
      ctt_pkg::WR_IDENT: wdata = {1'b1, idx_r[CODE_BITS-1:0]};
      ctt_pkg::WR_MAP:   wdata = {1'b1, val_r};
      default:           wdata = '0;
    endcase
  end

  always_comb begin
    case (cmd.res_sel)
      ctt_pkg::RES_DATA: res_x = CW'(rd_r[CODE_BITS-1:0]);
      ctt_pkg::RES_ADDR: res_x = CW'(addr_r);
      default:           res_x = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= cmd.rd_en;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_lo) begin
        idx_r <= {1'b0, lo_x[CODE_BITS-1:0]};
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.cmd;
      lo_r  <= in_ch.code_first;
      hi_r  <= in_ch.code_last;
      tgt_r <= in_ch.target_code;
    end
    if (cmd.rd_en) begin
      addr_r <= raddr;
    end
    if (cmd.val_ld) begin
      val_r <= tgt_x[CODE_BITS-1:0];
    end else if (cmd.wr_en) begin
      val_r <= val_r + 1'b1;
    end
    if (cmd.res_set) begin
      pend_st_r   <= cmd.res_st;
      pend_code_r <= res_x[ctt_pkg::CODE_W-1:0];
    end
    if (cmd.ld_out) begin
      out_st_r   <= pend_st_r;
      out_code_r <= pend_code_r;
    end
  end

  assign in_ch.ready        = cmd.in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.result_code = out_code_r;

  assign stat.in_valid  = in_ch.valid;
  assign stat.cmd       = ctt_pkg::cmd_t'(cmd_r);
  assign stat.lo_big    = lo_x > MAX_X;
  assign stat.order_bad = lo_x > hi_x;
  assign stat.hi_big    = hi_x > MAX_X;
  assign stat.set_ovf   = (tgt_x > MAX_X) || (span_end > MAX_X);
  assign stat.idx_at_hi = idx_r[CODE_BITS-1:0] == hi_x[CODE_BITS-1:0];
  assign stat.idx_last  = idx_r[CODE_BITS-1:0] == MAX_A;
  assign stat.idx_done  = idx_r[CODE_BITS];
  assign stat.rd_vbit   = rd_r[CODE_BITS];
  assign stat.hit       = pend_r && rd_r[CODE_BITS] && (CW'(rd_r[CODE_BITS-1:0]) == lo_x);
  assign stat.last_rd   = pend_r && (addr_r == MAX_A);
  assign stat.out_free  = !out_valid_r || out_ch.ready;

endmodule

// ===== src/char_translation_table_unit.sv =====
// Channel   Direction  Word
// in_ch     sink       cmd, code_first, code_last, target_code
// out_ch    source     status, result_code
//
// Table is one single-port-write memory of 2^CODE_BITS entries walked one entry
// per cycle. Reverse search walks it up to its end, restore walks all of it, set or
// unset of a range of N codes walks those N entries; translate and errors make no walk.
// After reset a clearing pass loads the identity map with in_ch.ready low. A finished
// word waits in the output register while the next item is taken.
module char_translation_table_unit #(
  parameter int CODE_BITS = ctt_pkg::CODE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ctt_in_if.sink     in_ch,
  ctt_out_if.source  out_ch
);

  ctt_pkg::ctrl_cmd_t cmd;
  ctt_pkg::dp_stat_t  stat;

  ctt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  ctt_dpath #(
    .CODE_BITS (CODE_BITS)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== src/ctt_checker.sv =====
module ctt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ctt_pkg::ST_W-1:0]   out_status,
  input logic [ctt_pkg::CODE_W-1:0] out_result_code
);

  // error results carry no code
  a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ctt_pkg::ST_OK |-> out_result_code == '0)
    else $error("nonzero result_code with error status");

  // one item at a time: ready drops right after a word is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // clearing pass runs after reset
  a_clear_pass: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("input ready during clearing pass");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_result_code))
    else $error("stalled result changed");

endmodule

bind char_translation_table_unit ctt_checker u_ctt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_result_code (out_ch.result_code)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ctt_pkg::*;

  localparam int TABLE_SIZE = 256;
  localparam int CODE_MAX = TABLE_SIZE - 1;
  localparam int PROBE_N = 25;
  localparam int PHASE_N = 5;
  localparam int PHASE_WORDS = 176;
  localparam int FLOOD_WORDS = 24;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 300;
  localparam int RUN_LIMIT_NS = 25_000_000;

  // commands the block must ignore
  localparam logic [CMD_W-1:0] CMD_NONE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NONE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NONE_C = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [CODE_W-1:0] lo;
    logic [CODE_W-1:0] hi;
    logic [CODE_W-1:0] tgt;
    logic              typed;
    status_t           st;
    logic [CODE_W-1:0] code;
  } probe_row_t;

  typedef struct packed {
    status_t           st;
    logic [CODE_W-1:0] code;
  } xlat_word_t;

  logic clk = 1'b0;
  logic rst_n;

  ctt_in_if  in_ch();
  ctt_out_if out_ch();

  char_translation_table_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted table contents
  logic [CODE_W-1:0] code_map [TABLE_SIZE];
  logic              code_ok  [TABLE_SIZE];

  xlat_word_t xlat_due [$];

  // side-band copy of a hand-typed expectation, driven with the word
  logic              typed_on;
  status_t           typed_st;
  logic [CODE_W-1:0] typed_code;

  int idle_pct;
  int stall_pct;
  int hold_asks;
  int err_cnt;
  int n_results;
  int n_cmd [8];
  int n_st [4];

  probe_row_t probes [PROBE_N];

  function automatic void table_apply(input logic [CMD_W-1:0] op,
                                      input logic [CODE_W-1:0] lo, hi, tgt,
                                      output status_t st, output logic [CODE_W-1:0] res);
    int k;
    st = ST_OK;
    res = '0;
    case (op)
      CMD_TRANS: begin
        if (!code_ok[lo]) st = ST_MISSING;
        else res = code_map[lo];
      end
      CMD_REV: begin
        st = ST_MISSING;
        for (k = 0; k < TABLE_SIZE; k++) begin
          if (st != ST_OK && code_ok[k] && code_map[k] == lo) begin
            st = ST_OK;
            res = k[CODE_W-1:0];
          end
        end
      end
      CMD_SET: begin
        if (lo > hi) st = ST_ORDER;
        else if (int'(tgt) + int'(hi) - int'(lo) > CODE_MAX) st = ST_OVERFLOW;
        else begin
          for (k = int'(lo); k <= int'(hi); k++) begin
            code_ok[k] = 1'b1;
            code_map[k] = CODE_W'(int'(tgt) + k - int'(lo));
          end
        end
      end
      CMD_UNSET: begin
        if (lo > hi) st = ST_ORDER;
        else begin
          for (k = int'(lo); k <= int'(hi); k++) begin
            code_ok[k] = 1'b0;
            code_map[k] = '0;
          end
        end
      end
      CMD_RESTORE: begin
        for (k = 0; k < TABLE_SIZE; k++) begin
          code_ok[k] = 1'b1;
          code_map[k] = k[CODE_W-1:0];
        end
      end
      default: ;
    endcase
    if (st != ST_OK) res = '0;
  endfunction

  // random word: mostly well-formed ranges of small size, some noise
  task automatic gen_word(output probe_row_t w);
    int r;
    int span;
    w = '0;
    w.lo = CODE_W'($urandom_range(0, CODE_MAX));
    w.hi = CODE_W'($urandom_range(0, CODE_MAX));
    w.tgt = CODE_W'($urandom_range(0, CODE_MAX));
    r = $urandom_range(0, 99);
    if (r < 35) begin
      w.op = CMD_TRANS;
    end else if (r < 55) begin
      w.op = CMD_REV;
      // aim at a code the table currently produces
      if ($urandom_range(0, 1) == 1) w.lo = code_map[$urandom_range(0, CODE_MAX)];
    end else if (r < 75) begin
      w.op = CMD_SET;
      if ($urandom_range(0, 99) < 85) begin
        span = ($urandom_range(0, 19) == 0) ? $urandom_range(0, CODE_MAX) : $urandom_range(0, 15);
        w.lo = CODE_W'($urandom_range(0, CODE_MAX - span));
        w.hi = w.lo + CODE_W'(span);
        w.tgt = CODE_W'($urandom_range(0, CODE_MAX - span));
      end
    end else if (r < 88) begin
      w.op = CMD_UNSET;
      if ($urandom_range(0, 99) < 85) begin
        span = $urandom_range(0, 7);
        w.lo = CODE_W'($urandom_range(0, CODE_MAX - span));
        w.hi = w.lo + CODE_W'(span);
      end
    end else if (r < 95) begin
      w.op = CMD_RESTORE;
    end else begin
      w.op = CMD_W'($urandom_range(CMD_NONE_A, CMD_NONE_C));
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input probe_row_t w);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= w.op;
    in_ch.code_first  <= w.lo;
    in_ch.code_last   <= w.hi;
    in_ch.target_code <= w.tgt;
    typed_on          <= w.typed;
    typed_st          <= w.st;
    typed_code        <= w.code;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (xlat_due.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    status_t           p_st;
    logic [CODE_W-1:0] p_code;
    xlat_word_t        e;
    if (rst_n) begin
      // check the result before queueing this edge's word
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        n_st[out_ch.status]++;
        if (xlat_due.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected: status=%0d code=%02h",
                   $time, out_ch.status, out_ch.result_code);
        end else begin
          e = xlat_due.pop_front();
          if (out_ch.status !== e.st || out_ch.result_code !== e.code) begin
            err_cnt++;
            $display("%0t: mismatch: expected status=%0d code=%02h, got status=%0d code=%02h",
                     $time, e.st, e.code, out_ch.status, out_ch.result_code);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        table_apply(in_ch.cmd, in_ch.code_first, in_ch.code_last, in_ch.target_code,
                    p_st, p_code);
        if (typed_on) begin
          e.st = typed_st;
          e.code = typed_code;
        end else begin
          e.st = p_st;
          e.code = p_code;
        end
        xlat_due.push_back(e);
        n_cmd[in_ch.cmd]++;
      end
    end
  end

  initial begin : rx_drive
    int hold_done;
    int hold_cnt;
    hold_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        out_ch.ready <= 1'b0;
        for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    probe_row_t w;
    int i;
    int p;
    int n;
    int k;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.code_first = '0;
    in_ch.code_last = '0;
    in_ch.target_code = '0;
    typed_on = 1'b0;
    typed_st = ST_OK;
    typed_code = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_asks = 0;
    err_cnt = 0;
    n_results = 0;
    for (k = 0; k < 8; k++) n_cmd[k] = 0;
    for (k = 0; k < 4; k++) n_st[k] = 0;
    for (k = 0; k < TABLE_SIZE; k++) begin
      code_ok[k] = 1'b1;
      code_map[k] = k[CODE_W-1:0];
    end

    probes = '{
      '{CMD_TRANS,   8'h00, 8'h00, 8'h00, 1'b1, ST_OK,       8'h00},
      '{CMD_TRANS,   8'hff, 8'h00, 8'h00, 1'b1, ST_OK,       8'hff},
      '{CMD_REV,     8'hab, 8'h00, 8'h00, 1'b1, ST_OK,       8'hab},
      '{CMD_SET,     8'h0a, 8'h05, 8'h00, 1'b1, ST_ORDER,    8'h00},
      '{CMD_UNSET,   8'hc8, 8'h64, 8'h00, 1'b1, ST_ORDER,    8'h00},
      '{CMD_SET,     8'h00, 8'h01, 8'hff, 1'b1, ST_OVERFLOW, 8'h00},
      '{CMD_SET,     8'h00, 8'hff, 8'h01, 1'b1, ST_OVERFLOW, 8'h00},
      '{CMD_SET,     8'h00, 8'hff, 8'h00, 1'b1, ST_OK,       8'h00},
      '{CMD_SET,     8'h41, 8'h5a, 8'h61, 1'b1, ST_OK,       8'h00},
      '{CMD_TRANS,   8'h41, 8'h00, 8'h00, 1'b0, ST_OK,       8'h00},
      '{CMD_REV,     8'h41, 8'h00, 8'h00, 1'b0, ST_OK,       8'h00},
      '{CMD_REV,     8'h61, 8'h00, 8'h00, 1'b0, ST_OK,       8'h00},
      '{CMD_SET,     8'h00, 8'h00, 8'hff, 1'b1, ST_OK,       8'h00},
      '{CMD_REV,     8'hff, 8'h00, 8'h00, 1'b0, ST_OK,       8'h00},
      '{CMD_UNSET,   8'h80, 8'hff, 8'h00, 1'b1, ST_OK,       8'h00},
      '{CMD_TRANS,   8'hff, 8'h00, 8'h00, 1'b0, ST_OK,       8'h00},
      '{CMD_UNSET,   8'h00, 8'hff, 8'h00, 1'b1, ST_OK,       8'h00},
      '{CMD_REV,     8'h00, 8'h00, 8'h00, 1'b0, ST_OK,       8'h00},
      '{CMD_SET,     8'h07, 8'h07, 8'h00, 1'b1, ST_OK,       8'h00},
      '{CMD_REV,     8'h00, 8'h00, 8'h00, 1'b0, ST_OK,       8'h00},
      '{CMD_NONE_A,  8'h12, 8'h34, 8'h56, 1'b1, ST_OK,       8'h00},
      '{CMD_NONE_B,  8'hff, 8'h00, 8'hff, 1'b1, ST_OK,       8'h00},
      '{CMD_NONE_C,  8'h00, 8'hff, 8'h00, 1'b1, ST_OK,       8'h00},
      '{CMD_RESTORE, 8'hff, 8'hff, 8'hff, 1'b1, ST_OK,       8'h00},
      '{CMD_TRANS,   8'h80, 8'h00, 8'h00, 1'b0, ST_OK,       8'h00}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the block clears its table after reset with ready low; the handshake covers it
    for (i = 0; i < PROBE_N; i++) send_word(probes[i]);
    in_ch.valid <= 1'b0;
    wait_drained();

    for (p = 0; p < PHASE_N; p++) begin
      case (p)
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        3: begin idle_pct = 25; stall_pct = 25; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (n = 0; n < PHASE_WORDS; n++) begin
        gen_word(w);
        send_word(w);
      end
      if (p == 0) begin
        // hold the output off and offer FLOOD_WORDS more words, so the input backs up
        hold_asks++;
        for (n = 0; n < FLOOD_WORDS; n++) begin
          gen_word(w);
          send_word(w);
        end
      end
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (xlat_due.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, xlat_due.size());
    end

    $display("Sent %0d translate, %0d reverse, %0d set, %0d unset, %0d restore, %0d unused words",
             n_cmd[CMD_TRANS], n_cmd[CMD_REV], n_cmd[CMD_SET], n_cmd[CMD_UNSET],
             n_cmd[CMD_RESTORE], n_cmd[CMD_NONE_A] + n_cmd[CMD_NONE_B] + n_cmd[CMD_NONE_C]);
    $display("Checked %0d results: %0d ok, %0d order, %0d overflow, %0d missing; %0d errors",
             n_results, n_st[ST_OK], n_st[ST_ORDER], n_st[ST_OVERFLOW], n_st[ST_MISSING],
             err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ctt_pkg.sv
src/ctt_if.sv
src/ctt_ctrl.sv
src/ctt_dpath.sv
src/char_translation_table_unit.sv
src/ctt_checker.sv
sim/testbench.sv
